FILE: hdl/ebdc_pkg.sv
// shared types, constants and helpers for the encoder/button dimmer control
package ebdc_pkg;

  localparam int LEVEL_W    = 7;
  localparam int STEP_W     = 5;
  localparam int HOLD_W     = 16;
  localparam int TIME_W     = 32;
  localparam int KELVIN_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_HOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_HOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESTORE_LEVEL = 3'd5;

  // register reset values
  localparam logic [STEP_W-1:0]  LEVEL_STEP_RST    = 5'd2;
  localparam logic [HOLD_W-1:0]  ROTATE_HOLD_RST   = 16'd20;
  localparam logic [HOLD_W-1:0]  BUTTON_HOLD_RST   = 16'd50;
  localparam logic [HOLD_W-1:0]  LONG_PRESS_RST    = 16'd2000;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST     = 7'd99;
  localparam logic [LEVEL_W-1:0] RESTORE_LEVEL_RST = 7'd50;

  localparam logic [LEVEL_W-1:0] LEVEL_RST = 7'd50;
  localparam logic [LEVEL_W-1:0] LEVEL_WAKE = 7'd1;

  localparam logic [KELVIN_W-1:0] KELVIN_WARM    = 13'd3000;
  localparam logic [KELVIN_W-1:0] KELVIN_NEUTRAL = 13'd4600;
  localparam logic [KELVIN_W-1:0] KELVIN_COLD    = 13'd6500;

  typedef struct packed {
    logic [STEP_W-1:0]  level_step;
    logic [HOLD_W-1:0]  rotate_holdoff_ms;
    logic [HOLD_W-1:0]  button_holdoff_ms;
    logic [HOLD_W-1:0]  long_press_ms;
    logic [LEVEL_W-1:0] max_level;
    logic [LEVEL_W-1:0] restore_level;
  } cfg_t;

  typedef struct packed {
    logic                prev_phase_a;
    logic [TIME_W-1:0]   last_step_time;
    logic [TIME_W-1:0]   press_start_time;
    logic                prev_button;
    logic                press_active;
    logic                press_consumed;
    logic                on_flag;
    logic [LEVEL_W-1:0]  level_first;
    logic [LEVEL_W-1:0]  level_second;
    logic                temp_mode;
    logic [KELVIN_W-1:0] kelvin;
  } state_t;

  typedef struct packed {
    logic                lamp_on;
    logic [LEVEL_W-1:0]  level_first;
    logic [LEVEL_W-1:0]  level_second;
    logic                temp_mode;
    logic [KELVIN_W-1:0] temp_kelvin;
    logic                save_request;
    logic                drive_update;
    logic                temp_apply;
  } result_t;

  // colour temperature cycle: warm -> neutral -> cold -> warm
  function automatic logic [KELVIN_W-1:0] kelvin_next(input logic [KELVIN_W-1:0] k);
    logic [KELVIN_W-1:0] r;
    if (k <= KELVIN_WARM) begin
      r = KELVIN_NEUTRAL;
    end else if (k >= KELVIN_COLD) begin
      r = KELVIN_WARM;
    end else if (k >= KELVIN_NEUTRAL) begin
      r = KELVIN_COLD;
    end else begin
      r = KELVIN_NEUTRAL;
    end
    return r;
  endfunction

endpackage

FILE: hdl/ebdc_step.sv
// next-state and result logic for one scan sample
module ebdc_step (
  input  ebdc_pkg::cfg_t                  cfg,
  input  ebdc_pkg::state_t                cur,
  input  logic                            phase_a,
  input  logic                            phase_b,
  input  logic                            button_level,
  input  logic [ebdc_pkg::TIME_W-1:0]     now_ms,
  output ebdc_pkg::state_t                nxt,
  output ebdc_pkg::result_t               res
);
  import ebdc_pkg::*;

  logic [TIME_W-1:0]  rot_diff;
  logic [TIME_W-1:0]  press_diff;
  logic               rot_ok;
  logic [LEVEL_W:0]   lv_sum;
  logic [LEVEL_W:0]   lv_up_raw;
  logic [LEVEL_W-1:0] lv_up;
  logic [LEVEL_W-1:0] lv_step;
  logic [LEVEL_W-1:0] lv_down;
  logic               save;
  logic               drive;
  logic               apply;

  assign rot_diff   = now_ms - cur.last_step_time;
  assign press_diff = now_ms - cur.press_start_time;
  assign rot_ok     = (phase_a != cur.prev_phase_a) &&
                      (rot_diff >= {{(TIME_W-HOLD_W){1'b0}}, cfg.rotate_holdoff_ms});

  // step up adds only below the limit, then clamps
  assign lv_step   = {{(LEVEL_W-STEP_W){1'b0}}, cfg.level_step};
  assign lv_sum    = {1'b0, cur.level_first} + {1'b0, lv_step};
  assign lv_up_raw = (cur.level_first < cfg.max_level) ? lv_sum : {1'b0, cur.level_first};
  assign lv_up     = (lv_up_raw > {1'b0, cfg.max_level}) ? cfg.max_level
                                                         : lv_up_raw[LEVEL_W-1:0];
  assign lv_down   = (cur.level_first > lv_step) ? (cur.level_first - lv_step)
                                                 : '0;

  always_comb begin
    nxt   = cur;
    save  = 1'b0;
    drive = 1'b0;
    apply = 1'b0;

    if (rot_ok) begin
      nxt.last_step_time = now_ms;
      if (!cur.on_flag) begin
        nxt.on_flag      = 1'b1;
        nxt.level_first  = LEVEL_WAKE;
        nxt.level_second = LEVEL_WAKE;
      end else if (phase_a != phase_b) begin
        nxt.level_first  = lv_up;
        nxt.level_second = lv_up;
      end else begin
        nxt.level_first  = lv_down;
        nxt.level_second = lv_down;
      end
      nxt.temp_mode = 1'b0;
      save  = 1'b1;
      drive = 1'b1;
    end
    nxt.prev_phase_a = phase_a;

    if (!button_level && cur.prev_button) begin
      // bounced edges leave the press state alone
      if (press_diff >= {{(TIME_W-HOLD_W){1'b0}}, cfg.button_holdoff_ms}) begin
        nxt.press_active     = 1'b1;
        nxt.press_consumed   = 1'b0;
        nxt.press_start_time = now_ms;
      end
    end else if (!button_level && cur.press_active && !cur.press_consumed) begin
      if (press_diff >= {{(TIME_W-HOLD_W){1'b0}}, cfg.long_press_ms}) begin
        nxt.press_consumed = 1'b1;
        if (!nxt.on_flag) begin
          nxt.on_flag      = 1'b1;
          nxt.level_first  = cfg.restore_level;
          nxt.level_second = cfg.restore_level;
        end
        nxt.temp_mode = 1'b1;
        nxt.kelvin    = kelvin_next(cur.kelvin);
        apply = 1'b1;
        save  = 1'b1;
      end
    end else if (button_level && !cur.prev_button) begin
      if (cur.press_active && !cur.press_consumed) begin
        if (!nxt.on_flag) begin
          if (nxt.level_first == '0) begin
            nxt.level_first = cfg.restore_level;
          end
          if (nxt.level_second == '0) begin
            nxt.level_second = cfg.restore_level;
          end
          nxt.on_flag = 1'b1;
        end else begin
          nxt.on_flag = 1'b0;
        end
        save  = 1'b1;
        drive = 1'b1;
      end
      nxt.press_active   = 1'b0;
      nxt.press_consumed = 1'b0;
    end
    nxt.prev_button = button_level;
  end

  always_comb begin
    res.lamp_on      = nxt.on_flag;
    res.level_first  = nxt.level_first;
    res.level_second = nxt.level_second;
    res.temp_mode    = nxt.temp_mode;
    res.temp_kelvin  = nxt.kelvin;
    res.save_request = save;
    res.drive_update = drive;
    res.temp_apply   = apply;
  end

endmodule

FILE: hdl/encoder_button_dimmer_control.sv
// top level: rotary encoder dimmer with short/long press button
// Each input beat is one scan sample (encoder phases, active-low button, ms
// timestamp) and yields exactly one output beat holding the lamp state after
// that sample plus the save/drive/apply pulses. A sample is accepted in any
// cycle where the output register is empty or is being emptied, so the block
// sustains one beat per clock while out_ready is high; the result appears in
// the next cycle. All per-sample work is a single pass of compare-and-update
// logic on the state registers, whose critical path is a 32-bit timestamp
// subtract and compare. Configuration writes land on the next clock edge and
// should only be issued while no beat is pending on the output.
module encoder_button_dimmer_control (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [ebdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ebdc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_phase_a,
  input  logic                                in_phase_b,
  input  logic                                in_button_level,
  input  logic [ebdc_pkg::TIME_W-1:0]         in_now_ms,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_lamp_on,
  output logic [ebdc_pkg::LEVEL_W-1:0]        out_level_first,
  output logic [ebdc_pkg::LEVEL_W-1:0]        out_level_second,
  output logic                                out_temp_mode,
  output logic [ebdc_pkg::KELVIN_W-1:0]       out_temp_kelvin,
  output logic                                out_save_request,
  output logic                                out_drive_update,
  output logic                                out_temp_apply
);
  import ebdc_pkg::*;

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t out_r;
  logic    out_valid_r;
  logic    in_fire;

  // output register empty or draining this cycle -> take a new sample
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration registers, each masked to its own width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_step        <= LEVEL_STEP_RST;
      cfg_r.rotate_holdoff_ms <= ROTATE_HOLD_RST;
      cfg_r.button_holdoff_ms <= BUTTON_HOLD_RST;
      cfg_r.long_press_ms     <= LONG_PRESS_RST;
      cfg_r.max_level         <= MAX_LEVEL_RST;
      cfg_r.restore_level     <= RESTORE_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVEL_STEP:    cfg_r.level_step        <= cfg_wdata[STEP_W-1:0];
        REG_ROTATE_HOLD:   cfg_r.rotate_holdoff_ms <= cfg_wdata[HOLD_W-1:0];
        REG_BUTTON_HOLD:   cfg_r.button_holdoff_ms <= cfg_wdata[HOLD_W-1:0];
        REG_LONG_PRESS:    cfg_r.long_press_ms     <= cfg_wdata[HOLD_W-1:0];
        REG_MAX_LEVEL:     cfg_r.max_level         <= cfg_wdata[LEVEL_W-1:0];
        REG_RESTORE_LEVEL: cfg_r.restore_level     <= cfg_wdata[LEVEL_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // per-sample update logic
  ebdc_step u_step (
    .cfg          (cfg_r),
    .cur          (state_r),
    .phase_a      (in_phase_a),
    .phase_b      (in_phase_b),
    .button_level (in_button_level),
    .now_ms       (in_now_ms),
    .nxt          (state_nxt),
    .res          (res_nxt)
  );

  // dimmer state, advanced once per accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.prev_phase_a     <= 1'b1;
      state_r.last_step_time   <= '0;
      state_r.press_start_time <= '0;
      state_r.prev_button      <= 1'b1;
      state_r.press_active     <= 1'b0;
      state_r.press_consumed   <= 1'b0;
      state_r.on_flag          <= 1'b0;
      state_r.level_first      <= LEVEL_RST;
      state_r.level_second     <= LEVEL_RST;
      state_r.temp_mode        <= 1'b0;
      state_r.kelvin           <= KELVIN_NEUTRAL;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // output register: valid is control, payload loads on accept only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lamp_on      = out_r.lamp_on;
  assign out_level_first  = out_r.level_first;
  assign out_level_second = out_r.level_second;
  assign out_temp_mode    = out_r.temp_mode;
  assign out_temp_kelvin  = out_r.temp_kelvin;
  assign out_save_request = out_r.save_request;
  assign out_drive_update = out_r.drive_update;
  assign out_temp_apply   = out_r.temp_apply;

`ifndef SYNTH
  // every accepted sample produces a beat on the next cycle
  a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted sample produced no result beat");

  // a colour temperature change always leaves temperature mode active
  a_apply_sets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.temp_apply) |-> out_r.temp_mode)
    else $error("temp_apply without temp_mode");

  // kelvin only ever holds the warm, neutral or cold point of the colour temperature sequence
  a_kelvin_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.kelvin == KELVIN_WARM || state_r.kelvin == KELVIN_NEUTRAL ||
    state_r.kelvin == KELVIN_COLD)
    else $error("kelvin left the warm/neutral/cold cycle");
`endif

endmodule

FILE: tb/sv/encoder_button_dimmer_control_tb.sv
// self-checking testbench for the encoder/button dimmer control block
module encoder_button_dimmer_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ebdc_pkg::*;

  // cycles without any accepted beat before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // length of the one long receiver hold-off that backs up the block
  localparam int LONG_STALL = 300;

  typedef struct packed {
    logic              phase_a;
    logic              phase_b;
    logic              button;
    logic [TIME_W-1:0] now_ms;
  } scan_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_phase_a = 1'b1;
  logic              in_phase_b = 1'b0;
  logic              in_button_level = 1'b1;
  logic [TIME_W-1:0] in_now_ms = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_lamp_on;
  logic [LEVEL_W-1:0]  out_level_first;
  logic [LEVEL_W-1:0]  out_level_second;
  logic                out_temp_mode;
  logic [KELVIN_W-1:0] out_temp_kelvin;
  logic                out_save_request;
  logic                out_drive_update;
  logic                out_temp_apply;

  encoder_button_dimmer_control u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_phase_a       (in_phase_a),
    .in_phase_b       (in_phase_b),
    .in_button_level  (in_button_level),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_lamp_on      (out_lamp_on),
    .out_level_first  (out_level_first),
    .out_level_second (out_level_second),
    .out_temp_mode    (out_temp_mode),
    .out_temp_kelvin  (out_temp_kelvin),
    .out_save_request (out_save_request),
    .out_drive_update (out_drive_update),
    .out_temp_apply   (out_temp_apply)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // scan samples waiting to be offered, and lamp states still to come out
  scan_t   scan_q[$];
  result_t lamp_state_q[$];
  int      mismatch_cnt = 0;

  // idle percentages of the two sides, changed between phases
  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 47;

  // one long receiver hold-off, requested by the stimulus, run by the receiver
  bit stall_armed = 1'b0;
  bit stall_done  = 1'b0;
  int stall_left  = 0;

  // ---------------------------------------------------------------------------
  // mirror of the configuration registers
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0]  step_cfg;
  logic [HOLD_W-1:0]  rot_hold_cfg;
  logic [HOLD_W-1:0]  btn_hold_cfg;
  logic [HOLD_W-1:0]  long_cfg;
  logic [LEVEL_W-1:0] max_cfg;
  logic [LEVEL_W-1:0] restore_cfg;

  // ---------------------------------------------------------------------------
  // dimmer state as the predictor sees it
  // ---------------------------------------------------------------------------
  logic                prev_a;
  logic [TIME_W-1:0]   last_step_ms;
  logic [TIME_W-1:0]   press_start_ms;
  logic                prev_btn;
  logic                press_held;
  logic                press_done;
  logic                lamp_lit;
  logic [LEVEL_W-1:0]  lvl_first;
  logic [LEVEL_W-1:0]  lvl_second;
  logic                tmode;
  logic [KELVIN_W-1:0] kelvin;

  function automatic void clear_dimmer();
    step_cfg       = LEVEL_STEP_RST;
    rot_hold_cfg   = ROTATE_HOLD_RST;
    btn_hold_cfg   = BUTTON_HOLD_RST;
    long_cfg       = LONG_PRESS_RST;
    max_cfg        = MAX_LEVEL_RST;
    restore_cfg    = RESTORE_LEVEL_RST;
    prev_a         = 1'b1;
    last_step_ms   = '0;
    press_start_ms = '0;
    prev_btn       = 1'b1;
    press_held     = 1'b0;
    press_done     = 1'b0;
    lamp_lit       = 1'b0;
    lvl_first      = LEVEL_RST;
    lvl_second     = LEVEL_RST;
    tmode          = 1'b0;
    kelvin         = KELVIN_NEUTRAL;
  endfunction

  // lamp state after one scan sample; updates the predicted dimmer state
  function automatic result_t next_lamp_state(input scan_t s);
    result_t           r;
    logic              save, drive, apply;
    int unsigned       lv;
    logic [TIME_W-1:0] since;
    save  = 1'b0;
    drive = 1'b0;
    apply = 1'b0;

    // encoder: any change of phase A outside the hold-off is one detent
    since = s.now_ms - last_step_ms;
    if (s.phase_a != prev_a && since >= TIME_W'(rot_hold_cfg)) begin
      last_step_ms = s.now_ms;
      if (!lamp_lit) begin
        // turning while dark wakes the lamp at the wake level, LEVEL_WAKE (1)
        lamp_lit  = 1'b1;
        lvl_first = LEVEL_WAKE;
      end else begin
        lv = 32'(lvl_first);
        if (s.phase_a != s.phase_b) begin
          if (lv < 32'(max_cfg)) lv = lv + 32'(step_cfg);
          if (lv > 32'(max_cfg)) lv = 32'(max_cfg);
        end else begin
          lv = (lv > 32'(step_cfg)) ? lv - 32'(step_cfg) : 32'd0;
        end
        lvl_first = LEVEL_W'(lv);
      end
      lvl_second = lvl_first;
      tmode      = 1'b0;
      save       = 1'b1;
      drive      = 1'b1;
    end
    prev_a = s.phase_a;

    // button, active low
    since = s.now_ms - press_start_ms;
    if (!s.button && prev_btn) begin
      // press edges close to the last press start are contact bounce
      if (since >= TIME_W'(btn_hold_cfg)) begin
        press_held     = 1'b1;
        press_done     = 1'b0;
        press_start_ms = s.now_ms;
      end
    end else if (!s.button && press_held && !press_done) begin
      if (since >= TIME_W'(long_cfg)) begin
        // long press: colour temperature step, handled once per press
        press_done = 1'b1;
        if (!lamp_lit) begin
          lamp_lit   = 1'b1;
          lvl_first  = restore_cfg;
          lvl_second = restore_cfg;
        end
        tmode = 1'b1;
        if (kelvin <= KELVIN_WARM) begin
          kelvin = KELVIN_NEUTRAL;
        end else if (kelvin >= KELVIN_COLD) begin
          kelvin = KELVIN_WARM;
        end else if (kelvin >= KELVIN_NEUTRAL) begin
          kelvin = KELVIN_COLD;
        end else begin
          kelvin = KELVIN_NEUTRAL;
        end
        apply = 1'b1;
        save  = 1'b1;
      end
    end else if (s.button && !prev_btn) begin
      if (press_held && !press_done) begin
        // short press toggles; zero levels come back at the restore level
        if (!lamp_lit) begin
          if (lvl_first == '0) lvl_first = restore_cfg;
          if (lvl_second == '0) lvl_second = restore_cfg;
          lamp_lit = 1'b1;
        end else begin
          lamp_lit = 1'b0;
        end
        save  = 1'b1;
        drive = 1'b1;
      end
      press_held = 1'b0;
      press_done = 1'b0;
    end
    prev_btn = s.button;

    r.lamp_on      = lamp_lit;
    r.level_first  = lvl_first;
    r.level_second = lvl_second;
    r.temp_mode    = tmode;
    r.temp_kelvin  = kelvin;
    r.save_request = save;
    r.drive_update = drive;
    r.temp_apply   = apply;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sample driver: offers queued samples, predicts each accepted beat
  // ---------------------------------------------------------------------------
  scan_t on_port;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        lamp_state_q.push_back(next_lamp_state(on_port));
      end
      // the port is free once nothing is pending or the pending beat went in
      if (!in_valid || in_ready) begin
        if (scan_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_port = scan_q.pop_front();
          in_phase_a      <= on_port.phase_a;
          in_phase_b      <= on_port.phase_b;
          in_button_level <= on_port.button;
          in_now_ms       <= on_port.now_ms;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: checks every accepted beat against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (lamp_state_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got lamp_on %0d level %0d/%0d",
                   $time, out_lamp_on, out_level_first, out_level_second);
          mismatch_cnt++;
        end else begin
          want = lamp_state_q.pop_front();
          check_field("lamp_on", 32'(want.lamp_on), 32'(out_lamp_on));
          check_field("level_first", 32'(want.level_first), 32'(out_level_first));
          check_field("level_second", 32'(want.level_second), 32'(out_level_second));
          check_field("temp_mode", 32'(want.temp_mode), 32'(out_temp_mode));
          check_field("temp_kelvin", 32'(want.temp_kelvin), 32'(out_temp_kelvin));
          check_field("save_request", 32'(want.save_request), 32'(out_save_request));
          check_field("drive_update", 32'(want.drive_update), 32'(out_drive_update));
          check_field("temp_apply", 32'(want.temp_apply), 32'(out_temp_apply));
        end
      end
      // receiver back-pressure: one long hold-off on request, else random
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (stall_armed && !stall_done) begin
        stall_done <= 1'b1;
        stall_left <= LONG_STALL;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any beat on either side ends the run
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] gen_ms = '0;
  logic              gen_a  = 1'b1;

  function automatic void push_sample(input logic a, input logic b, input logic btn,
                                      input logic [TIME_W-1:0] t);
    scan_t s;
    s.phase_a = a;
    s.phase_b = b;
    s.button  = btn;
    s.now_ms  = t;
    gen_ms    = t;
    gen_a     = a;
    scan_q.push_back(s);
  endfunction

  // gap around a hold-off: mostly past it, sometimes inside or right on it
  function automatic int unsigned near_gap(input int unsigned lim);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return $urandom_range(0, lim);
    if (pick == 2) return lim;
    return lim + $urandom_range(0, 40);
  endfunction

  // a held sample: button down, occasionally the knob turns as well
  function automatic void push_held(input int unsigned gap);
    logic a;
    a = ($urandom_range(0, 4) == 0) ? ~gen_a : gen_a;
    push_sample(a, 1'($urandom_range(0, 1)), 1'b0, gen_ms + gap);
  endfunction

  task automatic gen_random(input int n_items);
    int          goal, pick, reps, k;
    int unsigned sofar, g;
    logic        up, a;
    goal = scan_q.size() + n_items;
    while (scan_q.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // run of detents in one direction
        up   = 1'($urandom_range(0, 1));
        reps = $urandom_range(1, 10);
        for (k = 0; k < reps; k++) begin
          a = ~gen_a;
          push_sample(a, up ? ~a : a, 1'b1, gen_ms + near_gap(32'(rot_hold_cfg)));
        end
      end else if (pick < 55) begin
        // short press, held well under the long-press time
        push_sample(gen_a, 1'($urandom_range(0, 1)), 1'b0,
                    gen_ms + near_gap(32'(btn_hold_cfg)));
        reps = $urandom_range(0, 3);
        for (k = 0; k < reps; k++) push_held($urandom_range(0, long_cfg / 4));
        push_sample(gen_a, 1'($urandom_range(0, 1)), 1'b1, gen_ms + $urandom_range(0, 30));
      end else if (pick < 72) begin
        // long press: held samples until the long-press time is reached
        push_sample(gen_a, 1'($urandom_range(0, 1)), 1'b0,
                    gen_ms + btn_hold_cfg + $urandom_range(0, 20));
        reps  = $urandom_range(1, 3);
        sofar = 0;
        for (k = 0; k < reps - 1; k++) begin
          g = long_cfg / reps;
          sofar += g;
          push_held(g);
        end
        push_held(long_cfg - sofar + $urandom_range(0, 2));
        reps = $urandom_range(0, 2);
        for (k = 0; k < reps; k++) push_held($urandom_range(0, 50));
        push_sample(gen_a, 1'($urandom_range(0, 1)), 1'b1, gen_ms + $urandom_range(0, 30));
      end else if (pick < 82) begin
        // bouncing contact: a second press edge inside the button hold-off
        push_sample(gen_a, gen_a, 1'b0, gen_ms + near_gap(32'(btn_hold_cfg)));
        push_sample(gen_a, gen_a, 1'b1, gen_ms + $urandom_range(0, 3));
        push_sample(gen_a, gen_a, 1'b0, gen_ms + $urandom_range(0, btn_hold_cfg));
        push_sample(gen_a, gen_a, 1'b1, gen_ms + $urandom_range(0, 10));
      end else begin
        // noise: any levels, small steps or a jump anywhere in time
        reps = $urandom_range(1, 4);
        for (k = 0; k < reps; k++) begin
          push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)),
                      ($urandom_range(0, 9) < 7) ? gen_ms + $urandom_range(0, 100)
                                                 : TIME_W'($urandom()));
        end
      end
    end
  endtask

  // block until every queued sample went in and every result came out
  task automatic wait_drained();
    do @(negedge clk); while (scan_q.size() != 0 || in_valid || lamp_state_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    case (idx)
      REG_LEVEL_STEP:    step_cfg     = STEP_W'(data);
      REG_ROTATE_HOLD:   rot_hold_cfg = HOLD_W'(data);
      REG_BUTTON_HOLD:   btn_hold_cfg = HOLD_W'(data);
      REG_LONG_PRESS:    long_cfg     = HOLD_W'(data);
      REG_MAX_LEVEL:     max_cfg      = LEVEL_W'(data);
      REG_RESTORE_LEVEL: restore_cfg  = LEVEL_W'(data);
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned step, input int unsigned rot_hold,
                            input int unsigned btn_hold, input int unsigned long_ms,
                            input int unsigned max_lvl, input int unsigned restore);
    write_reg(REG_LEVEL_STEP, step);
    write_reg(REG_ROTATE_HOLD, rot_hold);
    write_reg(REG_BUTTON_HOLD, btn_hold);
    write_reg(REG_LONG_PRESS, long_ms);
    write_reg(REG_MAX_LEVEL, max_lvl);
    write_reg(REG_RESTORE_LEVEL, restore);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    cfg_we    = 1'b0;
    cfg_index = REG_LEVEL_STEP;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    clear_dimmer();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed walk through every behavior at the reset configuration
    push_sample(1'b1, 1'b0, 1'b1, 32'd10);          // no phase change
    push_sample(1'b1, 1'b0, 1'b0, 32'd30);          // press bounced against time zero
    push_sample(1'b1, 1'b0, 1'b1, 32'd40);          // release without a press
    push_sample(1'b0, 1'b1, 1'b1, 32'd100);         // turning while dark wakes at 1
    push_sample(1'b1, 1'b0, 1'b1, 32'd110);         // inside rotation hold-off
    push_sample(1'b0, 1'b1, 1'b1, 32'd130);         // step up
    push_sample(1'b1, 1'b1, 1'b1, 32'd150);         // step down
    push_sample(1'b0, 1'b0, 1'b1, 32'd170);         // step down floors at zero
    push_sample(1'b0, 1'b0, 1'b0, 32'd200);         // press
    push_sample(1'b0, 1'b0, 1'b0, 32'd300);         // held, short of long press
    push_sample(1'b0, 1'b0, 1'b1, 32'd320);         // short press turns off
    push_sample(1'b0, 1'b0, 1'b0, 32'd400);
    push_sample(1'b0, 1'b0, 1'b1, 32'd420);         // back on, zero levels restored
    push_sample(1'b0, 1'b0, 1'b0, 32'd500);
    push_sample(1'b0, 1'b0, 1'b0, 32'd2499);        // one ms short of long press
    push_sample(1'b0, 1'b0, 1'b0, 32'd2500);        // long press, neutral to cold
    push_sample(1'b0, 1'b0, 1'b0, 32'd2600);        // already handled
    push_sample(1'b0, 1'b0, 1'b1, 32'd2610);        // release after long press
    push_sample(1'b1, 1'b0, 1'b1, 32'd2620);        // rotation leaves temperature mode
    push_sample(1'b1, 1'b0, 1'b0, 32'd2700);
    push_sample(1'b1, 1'b0, 1'b1, 32'd2710);        // off again
    push_sample(1'b1, 1'b0, 1'b0, 32'd2800);
    push_sample(1'b1, 1'b0, 1'b0, 32'd4800);        // long press while dark
    push_sample(1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0);   // step just before the wrap
    push_sample(1'b1, 1'b0, 1'b0, 32'h0000_0004);   // hold-off measured across wrap
    push_sample(1'b1, 1'b0, 1'b1, 32'd8);
    wait_drained();

    // sender idles rarely, receiver often
    gen_random(270);
    wait_drained();
    set_config(16, 0, 0, 0, 127, 127);
    gen_random(270);
    wait_drained();

    // the other way round
    send_idle_pct = 47;
    recv_idle_pct = 9;
    set_config(1, 65535, 65535, 65535, 1, 1);
    gen_random(270);
    wait_drained();
    set_config(5, 7, 30, 300, 40, 127);
    gen_random(270);
    wait_drained();

    // no idling; the receiver backs up the block once with the knob at zero limits
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(0, 3, 10, 50, 0, 0);
    stall_armed = 1'b1;
    gen_random(270);
    wait_drained();
    set_config(16, 20, 50, 200, 126, 64);
    gen_random(270);
    wait_drained();

    // results come out in the cycle after acceptance, so a short tail catches strays
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && lamp_state_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
